// ===== rtl/tmtd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtd_pkg
// Shared types and constants of the thin micro-tile address generator:
// configuration layout, register indexes and the pipeline stage payloads.
// ----------------------------------------------------------------------------
package tmtd_pkg;

  // Field widths of the configuration registers and the coordinates.
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned BPE_W    = 5;
  localparam int unsigned COORD_W  = 14;
  localparam int unsigned SLICE_W  = 11;
  localparam int unsigned ADDR_W   = 43;
  localparam int unsigned CFG_IDX_W = 2;

  // A tile is TILE_DIM by TILE_DIM elements.
  localparam int unsigned TILE_DIM    = 8;
  localparam int unsigned TILE_SHIFT  = $clog2(TILE_DIM);
  localparam int unsigned ELEM_SHIFT  = 2 * TILE_SHIFT;
  localparam int unsigned TDIM_W      = DIM_W - TILE_SHIFT;    // tiles per row / column
  localparam int unsigned TCOORD_W    = COORD_W - TILE_SHIFT;  // tile coordinate

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_ELEMENT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] RST_SURFACE_WIDTH     = 15'd8;
  localparam logic [DIM_W-1:0] RST_SURFACE_HEIGHT    = 15'd8;
  localparam logic [BPE_W-1:0] RST_BYTES_PER_ELEMENT = 5'd4;

  // Configuration as seen by the pipeline.
  typedef struct packed {
    logic [DIM_W-1:0] surface_width;
    logic [DIM_W-1:0] surface_height;
    logic [BPE_W-1:0] bytes_per_element;
  } cfg_t;

  // After stage 1: first-level products.
  typedef struct packed {
    logic [2*TDIM_W-1:0]          tiles_per_slice;
    logic [2*DIM_W-1:0]           wh;
    logic [COORD_W+DIM_W-1:0]     row_lin;
    logic [TCOORD_W+TDIM_W-1:0]   row_tile;
    logic [TCOORD_W-1:0]          tile_x;
    logic [COORD_W-1:0]           x;
    logic [SLICE_W-1:0]           slice;
    logic [ELEM_SHIFT-1:0]        micro;
    logic                         oor;
  } s1_t;

  // After stage 2: slice products and in-slice partial sums.
  typedef struct packed {
    logic [SLICE_W+2*TDIM_W-1:0]   slice_tiles;
    logic [SLICE_W+2*DIM_W-1:0]    slice_lin;
    logic [TCOORD_W+TDIM_W:0]      tile_sum;
    logic [COORD_W+DIM_W:0]        lin_sum;
    logic [ELEM_SHIFT-1:0]         micro;
    logic                          oor;
  } s2_t;

  // After stage 3: element indexes before scaling by element size.
  typedef struct packed {
    logic [ADDR_W-1:0] tiled_elem;
    logic [ADDR_W-1:0] linear_elem;
    logic              oor;
  } s3_t;

  // After stage 4: the result transaction.
  typedef struct packed {
    logic [ADDR_W-1:0] tiled_byte_address;
    logic [ADDR_W-1:0] linear_byte_address;
    logic              out_of_range;
  } res_t;

endpackage

// ===== rtl/tmtd_prod.sv =====
// ----------------------------------------------------------------------------
// tmtd_prod
// Stages 1 and 2: surface products, row offsets and slice offsets in units
// of elements and tiles, with the range check and the micro-tile index.
// ----------------------------------------------------------------------------
module tmtd_prod (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tmtd_pkg::cfg_t                    cfg,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic [tmtd_pkg::COORD_W-1:0]      coord_x,
  input  logic [tmtd_pkg::COORD_W-1:0]      coord_y,
  input  logic [tmtd_pkg::SLICE_W-1:0]      coord_slice,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output tmtd_pkg::s2_t                     dn_data
);

  logic                 v1_r, v2_r;
  logic                 ready1, ready2;
  tmtd_pkg::s1_t        s1_r, s1_nxt;
  tmtd_pkg::s2_t        s2_r, s2_nxt;
  logic [tmtd_pkg::TDIM_W-1:0]   tiles_per_row;
  logic [tmtd_pkg::TDIM_W-1:0]   tile_rows;
  logic [tmtd_pkg::TCOORD_W-1:0] tile_y;

  // A stage takes a new transaction when it is empty or its content moves on.
  assign ready2   = !v2_r || dn_ready;
  assign ready1   = !v1_r || ready2;
  assign up_ready = ready1;

  assign tiles_per_row = cfg.surface_width[tmtd_pkg::DIM_W-1:tmtd_pkg::TILE_SHIFT];
  assign tile_rows     = cfg.surface_height[tmtd_pkg::DIM_W-1:tmtd_pkg::TILE_SHIFT];
  assign tile_y        = coord_y[tmtd_pkg::COORD_W-1:tmtd_pkg::TILE_SHIFT];

  // Stage 1: four independent products, the range check and the interleave.
  always_comb begin
    s1_nxt.tiles_per_slice = (2*tmtd_pkg::TDIM_W)'(tiles_per_row)
                           * (2*tmtd_pkg::TDIM_W)'(tile_rows);
    s1_nxt.wh       = (2*tmtd_pkg::DIM_W)'(cfg.surface_width)
                    * (2*tmtd_pkg::DIM_W)'(cfg.surface_height);
    s1_nxt.row_lin  = (tmtd_pkg::COORD_W+tmtd_pkg::DIM_W)'(coord_y)
                    * (tmtd_pkg::COORD_W+tmtd_pkg::DIM_W)'(cfg.surface_width);
    s1_nxt.row_tile = (tmtd_pkg::TCOORD_W+tmtd_pkg::TDIM_W)'(tile_y)
                    * (tmtd_pkg::TCOORD_W+tmtd_pkg::TDIM_W)'(tiles_per_row);
    s1_nxt.tile_x   = coord_x[tmtd_pkg::COORD_W-1:tmtd_pkg::TILE_SHIFT];
    s1_nxt.x        = coord_x;
    s1_nxt.slice    = coord_slice;
    s1_nxt.micro    = {coord_y[2], coord_x[2], coord_y[1], coord_x[1],
                       coord_y[0], coord_x[0]};
    s1_nxt.oor      = ({1'b0, coord_x} >= cfg.surface_width) ||
                      ({1'b0, coord_y} >= cfg.surface_height);
  end

  // Stage 2: slice products and the offsets within a slice.
  always_comb begin
    s2_nxt.slice_tiles = (tmtd_pkg::SLICE_W+2*tmtd_pkg::TDIM_W)'(s1_r.slice)
                       * (tmtd_pkg::SLICE_W+2*tmtd_pkg::TDIM_W)'(s1_r.tiles_per_slice);
    s2_nxt.slice_lin   = (tmtd_pkg::SLICE_W+2*tmtd_pkg::DIM_W)'(s1_r.slice)
                       * (tmtd_pkg::SLICE_W+2*tmtd_pkg::DIM_W)'(s1_r.wh);
    s2_nxt.tile_sum    = (tmtd_pkg::TCOORD_W+tmtd_pkg::TDIM_W+1)'(s1_r.row_tile)
                       + (tmtd_pkg::TCOORD_W+tmtd_pkg::TDIM_W+1)'(s1_r.tile_x);
    s2_nxt.lin_sum     = (tmtd_pkg::COORD_W+tmtd_pkg::DIM_W+1)'(s1_r.row_lin)
                       + (tmtd_pkg::COORD_W+tmtd_pkg::DIM_W+1)'(s1_r.x);
    s2_nxt.micro       = s1_r.micro;
    s2_nxt.oor         = s1_r.oor;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= up_valid;
      if (ready2) v2_r <= v1_r;
    end
  end

  // Payload registers load only with a transaction.
  always_ff @(posedge clk) begin
    if (up_valid && ready1) s1_r <= s1_nxt;
    if (v1_r && ready2)     s2_r <= s2_nxt;
  end

  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

endmodule

// ===== rtl/tmtd_sum.sv =====
// ----------------------------------------------------------------------------
// tmtd_sum
// Stage 3: adds the slice offsets to the in-slice offsets and forms the
// element indexes of the tiled and the linear layout.
// ----------------------------------------------------------------------------
module tmtd_sum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  tmtd_pkg::s2_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output tmtd_pkg::s3_t  dn_data
);

  logic                                      v3_r;
  tmtd_pkg::s3_t                             s3_r, s3_nxt;
  logic [tmtd_pkg::ADDR_W-tmtd_pkg::ELEM_SHIFT-1:0] tile_idx;

  assign up_ready = !v3_r || dn_ready;

  // Tile index scaled to elements, with the micro-tile index in the low bits.
  always_comb begin
    tile_idx = (tmtd_pkg::ADDR_W-tmtd_pkg::ELEM_SHIFT)'(up_data.slice_tiles)
             + (tmtd_pkg::ADDR_W-tmtd_pkg::ELEM_SHIFT)'(up_data.tile_sum);
    s3_nxt.tiled_elem  = {tile_idx, up_data.micro};
    s3_nxt.linear_elem = tmtd_pkg::ADDR_W'(up_data.slice_lin)
                       + tmtd_pkg::ADDR_W'(up_data.lin_sum);
    s3_nxt.oor         = up_data.oor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (up_ready) begin
      v3_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) s3_r <= s3_nxt;
  end

  assign dn_valid = v3_r;
  assign dn_data  = s3_r;

endmodule

// ===== rtl/tmtd_scale.sv =====
// ----------------------------------------------------------------------------
// tmtd_scale
// Stage 4: scales both element indexes by the element size and holds the
// result transaction in the output register.
// ----------------------------------------------------------------------------
module tmtd_scale (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tmtd_pkg::BPE_W-1:0]      bytes_per_element,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  tmtd_pkg::s3_t                   up_data,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output tmtd_pkg::res_t                  dn_data
);

  logic            v4_r;
  tmtd_pkg::res_t  res_r, res_nxt;

  assign up_ready = !v4_r || dn_ready;

  // Narrow multipliers by the element size; addresses wrap at their width.
  always_comb begin
    res_nxt.tiled_byte_address  = up_data.tiled_elem
                                * tmtd_pkg::ADDR_W'(bytes_per_element);
    res_nxt.linear_byte_address = up_data.linear_elem
                                * tmtd_pkg::ADDR_W'(bytes_per_element);
    res_nxt.out_of_range        = up_data.oor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (up_ready) begin
      v4_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) res_r <= res_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_data  = res_r;

endmodule

// ===== rtl/thin_micro_tile_detile_address.sv =====
// ----------------------------------------------------------------------------
// thin_micro_tile_detile_address
// Byte address generator for a 1D thin micro-tiled surface and its linear
// counterpart, one texel coordinate per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_*) carries one texel coordinate (x, y, slice) per
//   transaction; the output channel (out_*) returns the tiled byte address,
//   the linear byte address and an out-of-range flag for it, in order.
//   Surface width, height and bytes per element are written through the
//   cfg_* port while no transaction is in flight.
//   Throughput is one transaction per cycle while the receiver keeps up.
//   The result passes through four register stages: surface and row
//   products, slice products, offset sums, and scaling by element size.
//   Each stage holds its own valid bit and moves on when the next stage is
//   empty or moving, so bubbles close up under back-pressure. When the
//   receiver stalls, the result waits in the output register and the
//   stages behind it keep filling; in_ready falls only once all four
//   stages are occupied. A synchronous reset empties the pipeline and
//   restores the configuration registers to 8 x 8 elements of 4 bytes.
// ----------------------------------------------------------------------------
module thin_micro_tile_detile_address (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [tmtd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmtd_pkg::DIM_W-1:0]          cfg_wdata,
  // Coordinate channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tmtd_pkg::COORD_W-1:0]        in_coord_x,
  input  logic [tmtd_pkg::COORD_W-1:0]        in_coord_y,
  input  logic [tmtd_pkg::SLICE_W-1:0]        in_coord_slice,
  // Address channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tmtd_pkg::ADDR_W-1:0]         out_tiled_byte_address,
  output logic [tmtd_pkg::ADDR_W-1:0]         out_linear_byte_address,
  output logic                                out_out_of_range
);

  tmtd_pkg::cfg_t  cfg_r;
  tmtd_pkg::s2_t   s2_data;
  tmtd_pkg::s3_t   s3_data;
  tmtd_pkg::res_t  res_data;
  logic            s2_valid, s2_ready;
  logic            s3_valid, s3_ready;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_width     <= tmtd_pkg::RST_SURFACE_WIDTH;
      cfg_r.surface_height    <= tmtd_pkg::RST_SURFACE_HEIGHT;
      cfg_r.bytes_per_element <= tmtd_pkg::RST_BYTES_PER_ELEMENT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmtd_pkg::CFG_SURFACE_WIDTH:     cfg_r.surface_width     <= cfg_wdata;
        tmtd_pkg::CFG_SURFACE_HEIGHT:    cfg_r.surface_height    <= cfg_wdata;
        tmtd_pkg::CFG_BYTES_PER_ELEMENT:
          cfg_r.bytes_per_element <= cfg_wdata[tmtd_pkg::BPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stages 1 and 2.
  tmtd_prod u_prod (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .coord_x     (in_coord_x),
    .coord_y     (in_coord_y),
    .coord_slice (in_coord_slice),
    .dn_valid    (s2_valid),
    .dn_ready    (s2_ready),
    .dn_data     (s2_data)
  );

  // Stage 3.
  tmtd_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // Stage 4 and the output register.
  tmtd_scale u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .bytes_per_element (cfg_r.bytes_per_element),
    .up_valid          (s3_valid),
    .up_ready          (s3_ready),
    .up_data           (s3_data),
    .dn_valid          (out_valid),
    .dn_ready          (out_ready),
    .dn_data           (res_data)
  );

  assign out_tiled_byte_address  = res_data.tiled_byte_address;
  assign out_linear_byte_address = res_data.linear_byte_address;
  assign out_out_of_range        = res_data.out_of_range;

  // The input side can only be held off by a stalled, full output register.
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output register could move");

  // A stalled result stays in the output register, unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_tiled_byte_address)
      && $stable(out_linear_byte_address) && $stable(out_out_of_range)))
    else $error("stalled result changed before it was taken");

  // Reset empties the pipeline and opens the input.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

endmodule
